// ----- hdl/ctcgd_pkg.sv -----
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Types, constants and the exponent table of the greedy CTC decoder.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

	localparam int MAX_FRAMES = 1024;

	localparam int DICT_W = 14;
	localparam int IDX_W = 13;
	localparam int CONF_W = 17;
	localparam int SUM_W = 30;
	localparam int TOT_W = 27;
	localparam int NBF_W = $clog2(MAX_FRAMES) + 1;
	localparam int EXP_W = 17;
	localparam int DIV_W = 33;

	localparam logic [DICT_W-1:0] DICT_RESET = 14'd8192;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};
	localparam logic [NBF_W-1:0] NBF_MAX = {NBF_W{1'b1}};
	localparam logic [CONF_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		ST_ACCEPT,
		ST_FRAME,
		ST_PDIV,
		ST_POST,
		ST_MDIV,
		ST_MPOST,
		ST_OUT_CHAR,
		ST_OUT_SUM
	} state_t;

	typedef struct packed {
		logic accept;
		logic frame_start;
		logic pdiv_start;
		logic post_frame;
		logic mdiv_start;
		logic post_mean;
		logic out_char;
		logic out_sum;
	} ctcgd_cmd_t;

	typedef struct packed {
		logic frame_end;
		logic seq_end;
		logic div_busy;
		logic emit_char;
	} ctcgd_sts_t;

	function automatic logic [EXP_W-1:0] exp_entry(input int k);
		logic [63:0] v;
		logic [127:0] prod;
		v = 64'h1_0000_0000;
		for (int i = 0; i < k; i++) begin
			prod = v * 128'd4034748382 + 128'h8000_0000;
			v = prod[95:32];
		end
		exp_entry = EXP_W'((v + 64'd32768) >> 16);
	endfunction

endpackage

// ----- hdl/ctcgd_div.sv -----
// ----------------------------------------------------------------------------
// ctcgd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctcgd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ctcgd_pkg::DIV_W-1:0]   dividend,
	input  logic [ctcgd_pkg::SUM_W-1:0]   divisor,
	output logic                          busy,
	output logic [ctcgd_pkg::DIV_W-1:0]   quotient
);
	import ctcgd_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] num_q;
	logic [SUM_W:0]   rem_q;
	logic [SUM_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W+1:0] trial;

	assign trial = {rem_q, num_q[DIV_W-1]} - {2'b00, den_q};
	assign busy = (cnt_q != '0);
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy) begin
			if (!trial[SUM_W+1]) begin
				rem_q <= trial[SUM_W:0];
				num_q <= {num_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SUM_W-1:0], num_q[DIV_W-1]};
				num_q <= {num_q[DIV_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ----- hdl/ctcgd_datapath.sv -----
// ----------------------------------------------------------------------------
// ctcgd_datapath
// Online softmax, CTC collapse, sequence totals and output register.
// ----------------------------------------------------------------------------
module ctcgd_datapath #(
	parameter int MAX_CLASSES = 8192,
	parameter int LOGIT_WIDTH = 16,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctcgd_pkg::ctcgd_cmd_t         cmd,
	output ctcgd_pkg::ctcgd_sts_t         sts,
	input  logic [LOGIT_WIDTH-1:0]        logit,
	input  logic                          frame_end,
	input  logic                          sequence_end,
	input  logic                          cfg_we,
	input  logic [ctcgd_pkg::DICT_W-1:0]  cfg_data,
	output logic                          out_kind,
	output logic [ctcgd_pkg::IDX_W-1:0]   out_index,
	output logic [ctcgd_pkg::CONF_W-1:0]  out_conf,
	output logic                          out_last
);
	import ctcgd_pkg::*;

	localparam int CLS_W = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
	localparam int DIFF_W = LOGIT_WIDTH + 1;

	logic [DICT_W-1:0]      dict_q;
	logic signed [LOGIT_WIDTH-1:0] max_q;
	logic [CLS_W-1:0]       best_q;
	logic [CLS_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       sum_q;
	logic [IDX_W-1:0]       prev_q;
	logic [TOT_W-1:0]       tot_q;
	logic [NBF_W-1:0]       nbf_q;
	logic signed [LOGIT_WIDTH-1:0] x_q;
	logic                   fe_q;
	logic                   se_q;
	logic [EXP_W-1:0]       e_q;
	logic                   gt_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   emit_q;

	logic                   gt;
	logic [DIFF_W-1:0]      diff;
	logic [DIFF_W-5:0]      didx;
	logic [EXP_W-1:0]       e_val;
	logic [SUM_W+EXP_W:0]   prod;
	logic [SUM_W+EXP_W:0]   up_sum;
	logic [SUM_W:0]         add_sum;
	logic [SUM_W-1:0]       new_sum;
	logic [IDX_W-1:0]       best_idx;

	logic                   div_start;
	logic [DIV_W-1:0]       div_num;
	logic [SUM_W-1:0]       div_den;
	logic                   div_busy;
	logic [DIV_W-1:0]       div_q;
	logic [DIV_W-1:0]       p_clamp;
	logic [TOT_W:0]         tot_add;

	ctcgd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_q)
	);

	assign gt = x_q > max_q;
	assign diff = gt ? (DIFF_W'(x_q) - DIFF_W'(max_q)) : (DIFF_W'(max_q) - DIFF_W'(x_q));
	assign didx = diff[DIFF_W-1:4];

	always_comb begin
		e_val = '0;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			if (didx == (DIFF_W-4)'(k)) e_val = exp_entry(k);
		end
	end

	assign prod = (SUM_W+EXP_W+1)'(sum_q) * (SUM_W+EXP_W+1)'(e_q);
	assign up_sum = ((prod + (SUM_W+EXP_W+1)'(32768)) >> 16) + (SUM_W+EXP_W+1)'(65536);
	assign add_sum = (SUM_W+1)'(sum_q) + (SUM_W+1)'(e_q);
	always_comb begin
		if (gt_q) new_sum = (up_sum > (SUM_W+EXP_W+1)'(SUM_MAX)) ? SUM_MAX : up_sum[SUM_W-1:0];
		else new_sum = (add_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : add_sum[SUM_W-1:0];
	end

	// argmax including the logit being accumulated this cycle
	assign best_idx = IDX_W'(gt_q ? cnt_q : best_q);

	always_comb begin
		div_start = cmd.pdiv_start | cmd.mdiv_start;
		if (cmd.mdiv_start) begin
			div_num = DIV_W'(tot_q) + DIV_W'(nbf_q >> 1);
			div_den = SUM_W'(nbf_q);
		end else begin
			div_num = {1'b1, 32'd0} + DIV_W'(new_sum >> 1);
			div_den = new_sum;
		end
	end

	assign p_clamp = (div_q > DIV_W'(ONE_Q16)) ? DIV_W'(ONE_Q16) : div_q;
	assign tot_add = (TOT_W+1)'(tot_q) + (TOT_W+1)'(p_clamp);

	assign sts.frame_end = fe_q;
	assign sts.seq_end = se_q;
	assign sts.div_busy = div_busy;
	assign sts.emit_char = emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_q <= DICT_RESET;
			max_q <= {1'b1, {(LOGIT_WIDTH-1){1'b0}}};
			best_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
			prev_q <= '0;
			tot_q <= '0;
			nbf_q <= '0;
			idx_q <= '0;
			emit_q <= 1'b0;
		end else begin
			if (cfg_we) dict_q <= cfg_data;
			if (cmd.frame_start) begin
				sum_q <= new_sum;
				if (gt_q) begin
					max_q <= x_q;
					best_q <= cnt_q;
				end
				cnt_q <= (cnt_q == CLS_W'(MAX_CLASSES - 1)) ? '0 : cnt_q + 1'b1;
			end
			if (cmd.pdiv_start) begin
				idx_q <= best_idx;
				emit_q <= 1'b0;
			end
			if (cmd.post_frame) begin
				if (idx_q == '0) begin
					prev_q <= '0;
				end else begin
					emit_q <= (idx_q != prev_q) && (DICT_W'(idx_q) < dict_q);
					prev_q <= idx_q;
					tot_q <= (sum_q == '0) ? tot_q
						: (tot_add > (TOT_W+1)'(TOT_MAX)) ? TOT_MAX : tot_add[TOT_W-1:0];
					if (nbf_q != NBF_MAX) nbf_q <= nbf_q + 1'b1;
				end
				max_q <= {1'b1, {(LOGIT_WIDTH-1){1'b0}}};
				best_q <= '0;
				cnt_q <= '0;
				sum_q <= '0;
			end
			if (cmd.out_char) emit_q <= 1'b0;
			if (cmd.out_sum) begin
				prev_q <= '0;
				tot_q <= '0;
				nbf_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q <= logit;
			fe_q <= frame_end;
			se_q <= sequence_end;
		end
		e_q <= e_val;
		gt_q <= gt;
		if (cmd.out_char) begin
			out_kind <= KIND_CHAR;
			out_index <= idx_q;
			out_conf <= '0;
			out_last <= 1'b0;
		end
		if (cmd.post_mean) begin
			out_kind <= KIND_SUMMARY;
			out_index <= '0;
			out_conf <= (nbf_q == '0) ? '0 : p_clamp[CONF_W-1:0];
			out_last <= 1'b1;
		end
	end

endmodule

// ----- hdl/ctcgd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ctcgd_ctrl
// Sequencer for one logit: table lookup, accumulate, divides, output.
// ----------------------------------------------------------------------------
module ctcgd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  ctcgd_pkg::ctcgd_sts_t  sts,
	output ctcgd_pkg::ctcgd_cmd_t  cmd
);
	import ctcgd_pkg::*;

	state_t state_q, state_d;
	logic   step_q;
	logic   ov_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCEPT: if (s_tvalid && !ov_q) state_d = ST_FRAME;
			ST_FRAME: begin
				if (step_q) state_d = sts.frame_end ? ST_PDIV : ST_ACCEPT;
			end
			ST_PDIV: if (!sts.div_busy && step_q) state_d = ST_POST;
			ST_POST: state_d = ST_OUT_CHAR;
			ST_OUT_CHAR: begin
				if (!ov_q) begin
					if (sts.emit_char) state_d = ST_OUT_CHAR;
					else if (sts.seq_end) state_d = ST_MDIV;
					else state_d = ST_ACCEPT;
				end
			end
			ST_MDIV: if (!sts.div_busy && step_q) state_d = ST_MPOST;
			ST_MPOST: state_d = ST_OUT_SUM;
			ST_OUT_SUM: if (!ov_q) state_d = ST_ACCEPT;
			default: state_d = ST_ACCEPT;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_ACCEPT: begin
				s_tready = !ov_q;
				cmd.accept = s_tvalid && !ov_q;
			end
			ST_FRAME: begin
				cmd.frame_start = step_q;
				cmd.pdiv_start = step_q && sts.frame_end;
			end
			ST_POST: cmd.post_frame = 1'b1;
			ST_OUT_CHAR: begin
				cmd.out_char = !ov_q && sts.emit_char;
				cmd.mdiv_start = !ov_q && !sts.emit_char && sts.seq_end;
			end
			ST_MPOST: cmd.post_mean = 1'b1;
			ST_OUT_SUM: cmd.out_sum = !ov_q;
			default: ;
		endcase
	end

	assign m_tvalid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			step_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= (state_d == state_q) && !cmd.accept && !cmd.pdiv_start && !cmd.mdiv_start;
			if (cmd.out_char || cmd.post_mean) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
		end
	end

endmodule

// ----- hdl/ctc_greedy_decoder_with_confidence.sv -----
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_with_confidence
// Greedy CTC decoder with per-frame online softmax and sequence confidence.
// ----------------------------------------------------------------------------
// Flow: each logit is registered, its exponent is looked up and registered, and it is then
// accumulated; a frame end adds a divide for 1/sum and the collapse, an emitted character
// its output, a sequence end the mean divide and the summary; output stalls hold the flow.
// A new logit waits until the last has gone through the table lookup and the accumulate.
// Reset: arst_n clears the sequencer state, totals and output valid, and dictionary_size
// returns to 8192; the logit, exponent and output data registers are not reset.
module ctc_greedy_decoder_with_confidence #(
	parameter int MAX_CLASSES = 8192,
	parameter int LOGIT_WIDTH = 16,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ctcgd_pkg::DICT_W-1:0] cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [LOGIT_WIDTH-1:0]       s_tdata,   // logit
	input  logic                         s_tlast,   // frame_end
	input  logic                         s_tuser,   // sequence_end
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,   // char_index[12:0], confidence[29:13]
	output logic                         m_tuser,   // result_kind
	output logic                         m_tlast    // last
);
	import ctcgd_pkg::*;

	ctcgd_cmd_t cmd;
	ctcgd_sts_t sts;
	logic [IDX_W-1:0]  out_index;
	logic [CONF_W-1:0] out_conf;

	ctcgd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ctcgd_datapath #(
		.MAX_CLASSES     (MAX_CLASSES),
		.LOGIT_WIDTH     (LOGIT_WIDTH),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.logit        (s_tdata),
		.frame_end    (s_tlast),
		.sequence_end (s_tuser),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.out_kind     (m_tuser),
		.out_index    (out_index),
		.out_conf     (out_conf),
		.out_last     (m_tlast)
	);

	assign m_tdata = {2'b00, out_conf, out_index};

endmodule
